FILE: rtl/core/pcs_pkg.sv
// Shared types, constants and widths for the percentile contrast stretch block.
package pcs_pkg;

    localparam int NUM_BINS         = 255;
    localparam int BIN_W            = 8;
    localparam int PIX_W            = 8;
    localparam int FRAC_W           = 17;
    localparam int FRAME_PIXELS_MAX = 4194304;
    localparam int TOTAL_W          = $clog2(FRAME_PIXELS_MAX + 1);
    localparam int CNT_W            = TOTAL_W;
    localparam int TOT_LO_W         = 16;
    localparam int TOT_HI_W         = TOTAL_W - TOT_LO_W;
    localparam int LIM_W            = FRAC_W + TOTAL_W;
    localparam int SCALE_SH         = 16;

    localparam int DIV_NUM_W        = 17;
    localparam int DIV_DEN_W        = 9;
    localparam int DIV_STEPS        = 8;
    localparam int DIV_STEP_W       = $clog2(DIV_STEPS);

    localparam int CFG_IDX_W        = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;

    localparam logic [FRAC_W-1:0] LOWER_RESET = 17'd3277;
    localparam logic [FRAC_W-1:0] UPPER_RESET = 17'd62259;

    localparam logic REQ_COUNT   = 1'b0;
    localparam logic REQ_MAP     = 1'b1;
    localparam logic KIND_REPORT = 1'b0;
    localparam logic KIND_PIXEL  = 1'b1;

    localparam logic [PIX_W-1:0] PIX_MAX  = 8'hFF;
    localparam logic [BIN_W-1:0] LAST_BIN = BIN_W'(NUM_BINS - 1);

    typedef struct packed {
        logic             req_type;
        logic [PIX_W-1:0] pixel_in;
        logic             frame_last;
    } in_item_t;

    typedef struct packed {
        logic             result_kind;
        logic [PIX_W-1:0] pixel_out;
        logic [BIN_W-1:0] low_bin;
        logic [BIN_W-1:0] high_bin;
        logic             stretch_error;
    } out_item_t;

    typedef struct packed {
        logic             rd_en;
        logic [BIN_W-1:0] rd_addr;
        logic             wr_en;
        logic [BIN_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_data;
    } hist_cmd_t;

endpackage

FILE: rtl/core/percentile_contrast_stretch_top.sv
// Top level of the percentile contrast stretch block: histogram, bin walk and pixel mapping.
//
// Two-pass auto-levels for 8-bit gray pixels. Counting beats (req_type 0) are taken one per
// cycle while the block is idle; each does a read-modify-write of its bin in a 255-entry
// histogram RAM, with forwarding between back-to-back beats on the same bin. The counting
// beat marked frame_last starts the bin walk: a multiply and an add state build the two
// percentile limits, the walk reads and clears the bins one per cycle at the RAM port, and
// the drain and finish states load the bin report. A mapping beat (req_type 1) goes straight
// to the emit state when the result is a pass-through, 0 or 255, and through the 8-step
// divider otherwise. After reset the block zeroes the histogram, one bin per cycle, before it
// takes a beat; configuration writes are taken at any time and must be made only while the
// block is idle. A finished result waits in the output register while new beats are taken.
module percentile_contrast_stretch_top
    import pcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [FRAC_W-1:0]    cfg_data
);

    typedef enum logic [8:0] {
        ST_CLEAR   = 9'b000000001,
        ST_IDLE    = 9'b000000010,
        ST_LIM_MUL = 9'b000000100,
        ST_LIM_ADD = 9'b000001000,
        ST_WALK    = 9'b000010000,
        ST_DRAIN   = 9'b000100000,
        ST_FIN     = 9'b001000000,
        ST_DIV     = 9'b010000000,
        ST_EMIT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [FRAC_W-1:0]  lower_reg, upper_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               ovf_reg;
    logic               cnt_v_reg;
    logic [BIN_W-1:0]   cnt_bin_reg;
    logic [BIN_W-1:0]   clr_addr_reg;
    logic [BIN_W-1:0]   walk_addr_reg;
    logic               walk_dv_reg;
    logic [BIN_W-1:0]   walk_rdaddr_reg;

    logic [FRAC_W+TOT_LO_W-1:0] plo_lo_reg, pup_lo_reg;
    logic [FRAC_W+TOT_HI_W-1:0] plo_hi_reg, pup_hi_reg;
    logic [LIM_W-1:0]           lim_lo_reg, lim_hi_reg;

    logic [TOTAL_W-1:0] cum_reg;
    logic               found_lo_reg, found_hi_reg;
    logic [BIN_W-1:0]   lo_reg, hi_reg;
    logic [BIN_W-1:0]   st_low_reg, st_high_reg;
    logic               st_valid_reg;
    out_item_t          res_reg;
    logic               out_valid_reg;
    out_item_t          out_data_reg;

    hist_cmd_t          hcmd;
    logic [CNT_W-1:0]   hrd;

    logic               accept, count_acc, map_acc, room;
    logic [BIN_W-1:0]   in_bin;
    logic               out_free;
    logic [TOTAL_W-1:0] cum_new;
    logic [LIM_W-1:0]   scaled;
    logic               hit_lo, hit_hi;
    logic               walk_err;

    logic               map_zero, map_full, div_start, div_done;
    logic [PIX_W-1:0]   map_diff, map_den, div_quot;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign count_acc = accept && (in_data.req_type == REQ_COUNT);
    assign map_acc   = accept && (in_data.req_type == REQ_MAP);
    assign room      = total_reg < TOTAL_W'(FRAME_PIXELS_MAX);
    // floor(p*255/256) is p-1, except for black
    assign in_bin    = (in_data.pixel_in == '0) ? '0 : in_data.pixel_in - 1'b1;
    assign out_free  = !out_valid_reg || out_ready;

    assign cfg_ready = 1'b1;

    // mapping decode against the stored bins
    assign map_diff  = in_data.pixel_in - st_low_reg;
    assign map_den   = st_high_reg - st_low_reg;
    assign map_zero  = (in_data.pixel_in <= st_low_reg) || (st_high_reg <= st_low_reg);
    assign map_full  = in_data.pixel_in >= st_high_reg;
    assign div_start = map_acc && st_valid_reg && !map_zero && !map_full;
    // round(255*d/den) as (510*d + den) / (2*den)
    assign div_num   = DIV_NUM_W'({map_diff, 9'b0}) - DIV_NUM_W'({map_diff, 1'b0})
                     + DIV_NUM_W'(map_den);
    assign div_den   = {map_den, 1'b0};

    // walk datapath
    assign cum_new  = cum_reg + hrd;
    assign scaled   = LIM_W'({cum_new, SCALE_SH'(0)});
    assign hit_lo   = walk_dv_reg && !found_lo_reg && (scaled > lim_lo_reg);
    assign hit_hi   = walk_dv_reg && !found_hi_reg && (scaled > lim_hi_reg);
    assign walk_err = ovf_reg || !found_lo_reg || !found_hi_reg
                   || (lower_reg >= upper_reg) || (lo_reg == hi_reg);

    always_comb
    begin
        hcmd = '0;
        if (count_acc && room)
        begin
            hcmd.rd_en   = 1'b1;
            hcmd.rd_addr = in_bin;
        end
        else if (state_reg == ST_WALK)
        begin
            hcmd.rd_en   = 1'b1;
            hcmd.rd_addr = walk_addr_reg;
        end
        priority if (cnt_v_reg)
        begin
            hcmd.wr_en   = 1'b1;
            hcmd.wr_addr = cnt_bin_reg;
            hcmd.wr_data = hrd + 1'b1;
        end
        else if (walk_dv_reg)
        begin
            // clear each bin behind the walk
            hcmd.wr_en   = 1'b1;
            hcmd.wr_addr = walk_rdaddr_reg;
        end
        else if (state_reg == ST_CLEAR)
        begin
            hcmd.wr_en   = 1'b1;
            hcmd.wr_addr = clr_addr_reg;
        end
    end

    pcs_hist u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (hcmd),
        .rd_data (hrd)
    );

    pcs_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_addr_reg == LAST_BIN)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (count_acc && in_data.frame_last)
                begin
                    state_next = ST_LIM_MUL;
                end
                else if (div_start)
                begin
                    state_next = ST_DIV;
                end
                else if (map_acc)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_LIM_MUL: state_next = ST_LIM_ADD;
            ST_LIM_ADD: state_next = ST_WALK;
            ST_WALK:
            begin
                if (walk_addr_reg == LAST_BIN)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_FIN;
            ST_FIN:   state_next = ST_EMIT;
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            lower_reg     <= LOWER_RESET;
            upper_reg     <= UPPER_RESET;
            total_reg     <= '0;
            ovf_reg       <= 1'b0;
            cnt_v_reg     <= 1'b0;
            clr_addr_reg  <= '0;
            walk_dv_reg   <= 1'b0;
            st_low_reg    <= '0;
            st_high_reg   <= '0;
            st_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_v_reg   <= count_acc && room;
            walk_dv_reg <= (state_reg == ST_WALK);

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_LOWER)
                begin
                    lower_reg <= cfg_data;
                end
                else if (cfg_index == REG_UPPER)
                begin
                    upper_reg <= cfg_data;
                end
            end

            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end

            if (count_acc)
            begin
                if (room)
                begin
                    total_reg <= total_reg + 1'b1;
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end

            if (state_reg == ST_FIN)
            begin
                st_low_reg   <= lo_reg;
                st_high_reg  <= hi_reg;
                st_valid_reg <= !walk_err;
                total_reg    <= '0;
                ovf_reg      <= 1'b0;
            end

            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (count_acc)
        begin
            cnt_bin_reg <= in_bin;
        end

        if (state_reg == ST_LIM_MUL)
        begin
            plo_lo_reg <= lower_reg * total_reg[TOT_LO_W-1:0];
            plo_hi_reg <= lower_reg * total_reg[TOTAL_W-1:TOT_LO_W];
            pup_lo_reg <= upper_reg * total_reg[TOT_LO_W-1:0];
            pup_hi_reg <= upper_reg * total_reg[TOTAL_W-1:TOT_LO_W];
        end

        if (state_reg == ST_LIM_ADD)
        begin
            lim_lo_reg    <= LIM_W'(plo_lo_reg) + {plo_hi_reg, TOT_LO_W'(0)};
            lim_hi_reg    <= LIM_W'(pup_lo_reg) + {pup_hi_reg, TOT_LO_W'(0)};
            cum_reg       <= '0;
            found_lo_reg  <= 1'b0;
            found_hi_reg  <= 1'b0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            walk_addr_reg <= '0;
        end

        if (state_reg == ST_WALK)
        begin
            walk_addr_reg <= walk_addr_reg + 1'b1;
        end
        walk_rdaddr_reg <= walk_addr_reg;

        if (walk_dv_reg)
        begin
            cum_reg <= cum_new;
            if (hit_lo)
            begin
                found_lo_reg <= 1'b1;
                lo_reg       <= walk_rdaddr_reg;
            end
            if (hit_hi)
            begin
                found_hi_reg <= 1'b1;
                hi_reg       <= walk_rdaddr_reg;
            end
        end

        if (map_acc)
        begin
            res_reg.result_kind   <= KIND_PIXEL;
            res_reg.low_bin       <= st_low_reg;
            res_reg.high_bin      <= st_high_reg;
            res_reg.stretch_error <= !st_valid_reg;
            priority if (!st_valid_reg)
            begin
                res_reg.pixel_out <= in_data.pixel_in;
            end
            else if (map_zero)
            begin
                res_reg.pixel_out <= '0;
            end
            else
            begin
                res_reg.pixel_out <= PIX_MAX;
            end
        end
        else if (state_reg == ST_DIV && div_done)
        begin
            res_reg.pixel_out <= div_quot;
        end
        else if (state_reg == ST_FIN)
        begin
            res_reg.result_kind   <= KIND_REPORT;
            res_reg.pixel_out     <= '0;
            res_reg.low_bin       <= lo_reg;
            res_reg.high_bin      <= hi_reg;
            res_reg.stretch_error <= walk_err;
        end

        if (state_reg == ST_EMIT && out_free)
        begin
            out_data_reg <= res_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

FILE: rtl/core/pcs_hist.sv
// Histogram memory: one read and one write port, read data forwarded from a same-edge write.
module pcs_hist
    import pcs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  hist_cmd_t        cmd,
    output logic [CNT_W-1:0] rd_data
);

    logic [CNT_W-1:0] mem_r [NUM_BINS];
    logic [CNT_W-1:0] q_reg;
    logic [BIN_W-1:0] rd_addr_reg;
    logic             fwd_v_reg;
    logic [BIN_W-1:0] fwd_addr_reg;
    logic [CNT_W-1:0] fwd_data_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem_r[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            q_reg       <= mem_r[cmd.rd_addr];
            rd_addr_reg <= cmd.rd_addr;
        end
        fwd_addr_reg <= cmd.wr_addr;
        fwd_data_reg <= cmd.wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_v_reg <= 1'b0;
        end
        else
        begin
            fwd_v_reg <= cmd.wr_en;
        end
    end

    // a write on the same edge as the read is not seen by the array read
    assign rd_data = (fwd_v_reg && fwd_addr_reg == rd_addr_reg) ? fwd_data_reg : q_reg;

endmodule

FILE: rtl/core/pcs_div.sv
// Restoring divider, one quotient bit per cycle, for the rounded stretch ratio.
module pcs_div
    import pcs_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_NUM_W-1:0] num,
    input  logic [DIV_DEN_W-1:0] den,
    output logic                 done,
    output logic [PIX_W-1:0]     quot
);

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_STEP_W-1:0] step_reg;
    logic [DIV_NUM_W-1:0]  rem_reg;
    logic [DIV_NUM_W-1:0]  dsh_reg;
    logic [PIX_W-1:0]      q_reg;
    logic                  fits;

    assign fits = rem_reg >= dsh_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == DIV_STEP_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= num;
            dsh_reg <= DIV_NUM_W'(den) << (DIV_STEPS - 1);
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= rem_reg - dsh_reg;
            end
            q_reg   <= {q_reg[PIX_W-2:0], fits};
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

FILE: rtl/core/pcs_checker.sv
// Port-level checks for the percentile contrast stretch block, bound to the top level.
module pcs_checker
    import pcs_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      out_valid,
    input logic      out_ready,
    input out_item_t out_data
);

    // hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    a_report_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.result_kind == KIND_REPORT |-> out_data.pixel_out == '0)
        else $error("bin report carries a pixel");

    a_bins_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.low_bin <= LAST_BIN && out_data.high_bin <= LAST_BIN)
        else $error("bin out of range");

    // a clean stretch always has the low bin strictly below the high bin
    a_clean_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.stretch_error |-> out_data.low_bin < out_data.high_bin)
        else $error("clean stretch with unordered bins");

endmodule

bind percentile_contrast_stretch_top pcs_checker u_pcs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

FILE: tb/tb_percentile_contrast_stretch_top.sv
// Self-checking testbench for the percentile contrast stretch block.
module tb_percentile_contrast_stretch_top;
    import pcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE3 = 2'd3;
    localparam int WALK_CYCLES = 300;
    localparam int LONG_HOLD   = 400;
    localparam int ITEM_GOAL   = 440;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [FRAC_W-1:0]    cfg_data  = '0;

    percentile_contrast_stretch_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Shadow copy of the block's state and registers
    logic [FRAC_W-1:0] lower_q16 = LOWER_RESET;
    logic [FRAC_W-1:0] upper_q16 = UPPER_RESET;
    int unsigned       hist_bins [NUM_BINS];
    int unsigned       pixel_count = 0;
    logic [BIN_W-1:0]  held_lo = '0;
    logic [BIN_W-1:0]  held_hi = '0;
    bit                stretch_ok = 1'b0;
    bit                count_sat = 1'b0;

    in_item_t  pixel_queue [$];
    out_item_t levels_due [$];
    int        items_queued = 0;
    int        items_taken  = 0;
    int        errors       = 0;
    bit        idle_on      = 1'b1;
    int        holds_asked  = 0;
    int        holds_done   = 0;
    int        send_gap     = 0;
    int        stall_left   = 0;

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    task automatic flag_error(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    function automatic logic [PIX_W-1:0] stretch_pixel(input logic [PIX_W-1:0] p);
        int diff;
        int den;
        int q;
        diff = int'(p) - int'(held_lo);
        den  = int'(held_hi) - int'(held_lo);
        if (diff <= 0 || den <= 0)
            return '0;
        q = (2 * int'(PIX_MAX) * diff + den) / (2 * den);
        if (q > int'(PIX_MAX))
            q = int'(PIX_MAX);
        return PIX_W'(q);
    endfunction

    // Advance the shadow state by one accepted beat and queue the result it causes
    task automatic auto_levels(input in_item_t beat);
        out_item_t       res;
        longint unsigned running;
        longint unsigned lim_lo;
        longint unsigned lim_hi;
        bit              found_lo;
        bit              found_hi;
        bit              bad;
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
        int unsigned     b;
        res = '0;
        if (beat.req_type == REQ_MAP)
        begin
            res.result_kind   = KIND_PIXEL;
            res.pixel_out     = stretch_ok ? stretch_pixel(beat.pixel_in) : beat.pixel_in;
            res.low_bin       = held_lo;
            res.high_bin      = held_hi;
            res.stretch_error = !stretch_ok;
            levels_due = {levels_due, res};
            return;
        end
        if (pixel_count >= FRAME_PIXELS_MAX)
        begin
            count_sat = 1'b1;
        end
        else
        begin
            b = (int'(beat.pixel_in) * NUM_BINS) >> 8;
            hist_bins[b]++;
            pixel_count++;
        end
        if (!beat.frame_last)
            return;
        running  = 0;
        lim_lo   = longint'(lower_q16) * pixel_count;
        lim_hi   = longint'(upper_q16) * pixel_count;
        found_lo = 1'b0;
        found_hi = 1'b0;
        lo       = '0;
        hi       = '0;
        for (int i = 0; i < NUM_BINS; i++)
        begin
            running += hist_bins[i];
            if (!found_lo && (running << SCALE_SH) > lim_lo)
            begin
                found_lo = 1'b1;
                lo       = BIN_W'(i);
            end
            if (!found_hi && (running << SCALE_SH) > lim_hi)
            begin
                found_hi = 1'b1;
                hi       = BIN_W'(i);
            end
        end
        bad = count_sat || !found_lo || !found_hi || lower_q16 >= upper_q16 || lo == hi;
        held_lo    = lo;
        held_hi    = hi;
        stretch_ok = !bad;
        res.result_kind   = KIND_REPORT;
        res.low_bin       = lo;
        res.high_bin      = hi;
        res.stretch_error = bad;
        levels_due = {levels_due, res};
        foreach (hist_bins[i])
            hist_bins[i] = 0;
        pixel_count = 0;
        count_sat   = 1'b0;
    endtask

    // Pixel sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            send_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                auto_levels(in_data);
                items_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pixel_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= pixel_queue.pop_front();
                    if (idle_on && $urandom_range(0, 7) == 0)
                        send_gap = $urandom_range(1, 12);
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls, plus a long hold when one is asked for
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (holds_done != holds_asked)
            begin
                holds_done++;
                stall_left = LONG_HOLD;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 11);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : watch
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (levels_due.size() == 0)
            begin
                flag_error("result with nothing pending", int'(out_data.result_kind), -1);
            end
            else
            begin
                want = levels_due.pop_front();
                if (out_data.result_kind !== want.result_kind)
                    flag_error("result_kind", int'(out_data.result_kind),
                               int'(want.result_kind));
                if (out_data.pixel_out !== want.pixel_out)
                    flag_error("pixel_out", int'(out_data.pixel_out), int'(want.pixel_out));
                if (out_data.low_bin !== want.low_bin)
                    flag_error("low_bin", int'(out_data.low_bin), int'(want.low_bin));
                if (out_data.high_bin !== want.high_bin)
                    flag_error("high_bin", int'(out_data.high_bin), int'(want.high_bin));
                if (out_data.stretch_error !== want.stretch_error)
                    flag_error("stretch_error", int'(out_data.stretch_error),
                               int'(want.stretch_error));
            end
        end
    end

    task automatic queue_count(input int pix, input bit last);
        in_item_t beat;
        beat.req_type   = REQ_COUNT;
        beat.pixel_in   = PIX_W'(pix);
        beat.frame_last = last;
        pixel_queue = {pixel_queue, beat};
        items_queued++;
    endtask

    task automatic queue_map(input int pix, input bit last);
        in_item_t beat;
        beat.req_type   = REQ_MAP;
        beat.pixel_in   = PIX_W'(pix);
        beat.frame_last = last;
        pixel_queue = {pixel_queue, beat};
        items_queued++;
    endtask

    // Hold until every beat is taken and every result is back
    task automatic wait_drained();
        while (items_taken != items_queued || levels_due.size() != 0)
            @(posedge clk);
    endtask

    // Drain, then let a possible bin walk finish before touching registers
    task automatic settle();
        wait_drained();
        repeat (WALK_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FRAC_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LOWER)
            lower_q16 = value;
        else if (idx == REG_UPPER)
            upper_q16 = value;
    endtask

    // A frame of clustered pixels; an occasional map beat lands mid-frame
    task automatic queue_frame(input int n, input bit close);
        int base;
        int span;
        base = $urandom_range(0, 255);
        span = $urandom_range(0, 255 - base);
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 11) == 0)
                queue_map($urandom_range(0, 255), 1'($urandom_range(0, 1)));
            queue_count(base + $urandom_range(0, span), close && i == n - 1);
        end
    endtask

    initial
    begin
        int phase;
        int pick;
        int lo_val;
        int hi_val;
        int first_frame [10];
        first_frame = '{0, 255, 128, 1, 254, 64, 200, 100, 150, 50};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Reset percentiles; maps before any report pass through
        queue_map(0, 1'b0);
        queue_map(255, 1'b1);
        foreach (first_frame[i])
            queue_count(first_frame[i], i == 9);
        queue_map(0, 1'b0);
        queue_map(255, 1'b1);
        queue_map(128, 1'b0);
        queue_map(1, 1'b1);
        queue_map(253, 1'b0);
        // Narrow frame: pixels below and above the bins clamp
        queue_count(60, 1'b0);
        queue_count(70, 1'b0);
        queue_count(80, 1'b0);
        queue_count(90, 1'b1);
        queue_map(10, 1'b0);
        queue_map(200, 1'b0);
        queue_map(75, 1'b0);
        // Single pixel frame gives equal bins
        queue_count(77, 1'b1);
        queue_map(77, 1'b0);
        settle();

        // Upper fraction of one is never crossed
        write_reg(REG_LOWER, 17'd0);
        write_reg(REG_UPPER, 17'd65536);
        queue_frame(8, 1'b1);
        queue_map(100, 1'b0);
        settle();

        // Equal percentiles
        write_reg(REG_LOWER, 17'd65535);
        write_reg(REG_UPPER, 17'd65535);
        queue_frame(6, 1'b1);
        queue_map(33, 1'b0);
        settle();

        // Out of order, lower above one; spare indexes are ignored
        write_reg(REG_LOWER, 17'h1FFFF);
        write_reg(REG_UPPER, 17'd0);
        write_reg(REG_SPARE2, 17'd0);
        write_reg(REG_SPARE3, 17'h1FFFF);
        queue_frame(5, 1'b1);
        queue_map(200, 1'b0);
        settle();

        write_reg(REG_LOWER, 17'd1);
        write_reg(REG_UPPER, 17'd65535);
        queue_frame(12, 1'b1);
        for (int i = 0; i < 4; i++)
            queue_map($urandom_range(0, 255), 1'b0);
        settle();

        phase = 0;
        while (items_queued < ITEM_GOAL)
        begin
            if (items_queued > ITEM_GOAL - 110)
                idle_on = 1'b0;
            else
                idle_on = (phase % 5) != 4;
            if ($urandom_range(0, 3) == 0)
            begin
                settle();
                pick = $urandom_range(0, 5);
                unique case (pick)
                    0:
                    begin
                        lo_val = int'(LOWER_RESET);
                        hi_val = int'(UPPER_RESET);
                    end
                    1:
                    begin
                        lo_val = 0;
                        hi_val = 65536;
                    end
                    2:
                    begin
                        lo_val = $urandom_range(0, 65536);
                        hi_val = lo_val;
                    end
                    3:
                    begin
                        hi_val = $urandom_range(0, 40000);
                        lo_val = $urandom_range(hi_val, 65536);
                    end
                    4:
                    begin
                        lo_val = $urandom_range(0, 17'h1FFFF);
                        hi_val = $urandom_range(0, 17'h1FFFF);
                    end
                    default:
                    begin
                        lo_val = $urandom_range(0, 20000);
                        hi_val = $urandom_range(45000, 65536);
                    end
                endcase
                write_reg(REG_LOWER, FRAC_W'(lo_val));
                write_reg(REG_UPPER, FRAC_W'(hi_val));
            end
            // Mostly closed frames; now and then one runs on into the next phase
            queue_frame($urandom_range(1, 30), $urandom_range(0, 5) != 0);
            if (phase == 3)
                holds_asked++;
            for (int i = $urandom_range(3, phase == 3 ? 40 : 20); i > 0; i--)
                queue_map($urandom_range(0, 255), 1'($urandom_range(0, 1)));
            wait_drained();
            phase++;
        end

        wait_drained();
        repeat (WALK_CYCLES) @(posedge clk);
        if (levels_due.size() != 0)
            flag_error("results never returned", levels_due.size(), 0);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
